>>> design/hbwd_pkg.sv
// ---------------------------------------------------------------------------
// hbwd_pkg
// Shared types and constants for the heartbeat watchdog fault register.
// ---------------------------------------------------------------------------
package hbwd_pkg;

	localparam int unsigned TIMEOUT_W = 32;
	localparam int unsigned TICK_W    = 32;
	localparam int unsigned FAULT_W   = 32;
	localparam int unsigned KIND_W    = 3;
	localparam int unsigned REG_IDX_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_MONITOR  = 3'd0,
		KIND_BEAT_POS = 3'd1,
		KIND_BEAT_INR = 3'd2,
		KIND_BEAT_BUS = 3'd3,
		KIND_SET_MASK = 3'd4,
		KIND_CLR_MASK = 3'd5
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_POS_TIMEOUT = 2'd0,
		REG_INR_TIMEOUT = 2'd1,
		REG_BUS_TIMEOUT = 2'd2
	} reg_idx_t;

	localparam logic [TIMEOUT_W-1:0] RST_POS_TIMEOUT = 32'd2000;
	localparam logic [TIMEOUT_W-1:0] RST_INR_TIMEOUT = 32'd500;
	localparam logic [TIMEOUT_W-1:0] RST_BUS_TIMEOUT = 32'd1000;

	// fault word bit positions
	localparam int unsigned BIT_POS = 0;
	localparam int unsigned BIT_INR = 1;
	localparam int unsigned BIT_BUS = 2;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] pos;
		logic [TIMEOUT_W-1:0] inr;
		logic [TIMEOUT_W-1:0] bus;
	} timeouts_t;

endpackage

>>> design/hbwd_cfg_regs.sv
// ---------------------------------------------------------------------------
// hbwd_cfg_regs
// Timeout registers, written through a plain write port.
// ---------------------------------------------------------------------------
module hbwd_cfg_regs
	import hbwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	output timeouts_t            timeouts
);

	timeouts_t timeouts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeouts_q.pos <= RST_POS_TIMEOUT;
			timeouts_q.inr <= RST_INR_TIMEOUT;
			timeouts_q.bus <= RST_BUS_TIMEOUT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_POS_TIMEOUT: timeouts_q.pos <= cfg_data;
				REG_INR_TIMEOUT: timeouts_q.inr <= cfg_data;
				REG_BUS_TIMEOUT: timeouts_q.bus <= cfg_data;
				default: ;
			endcase
		end
	end

	assign timeouts = timeouts_q;

endmodule

>>> design/hbwd_chan_check.sv
// ---------------------------------------------------------------------------
// hbwd_chan_check
// One channel: wrapping age against timeout, next fault bit and action pulse.
// ---------------------------------------------------------------------------
module hbwd_chan_check
	import hbwd_pkg::*;
#(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic [TICK_W-1:0]                              now_tick,
	input  logic [((TICK_BITS < 32) ? TICK_BITS : 32)-1:0] stamp,
	input  logic [TIMEOUT_W-1:0]                           timeout,
	input  logic                                           bit_cur,
	output logic                                           bit_next,
	output logic                                           pulse
);

	localparam int unsigned CMP_W = (TICK_BITS > 32) ? TICK_BITS : 32;

	logic [TICK_BITS-1:0] now_x;
	logic [TICK_BITS-1:0] stamp_x;
	logic [TICK_BITS-1:0] age;
	logic                 overdue;

	always_comb begin
		now_x    = TICK_BITS'(now_tick);
		stamp_x  = TICK_BITS'(stamp);
		age      = now_x - stamp_x;
		overdue  = CMP_W'(age) > CMP_W'(timeout);
		bit_next = overdue;
		pulse    = overdue & ~bit_cur;
	end

endmodule

>>> design/heartbeat_watchdog_fault_register_core.sv
// ---------------------------------------------------------------------------
// heartbeat_watchdog_fault_register_core
// Three-channel heartbeat watchdog with a 32-bit fault word.
// ---------------------------------------------------------------------------
// Every transaction on the input stream gives exactly one result transaction.
// The block takes one item per clock when the result side does not stall it:
// the item sits in an input register, a single pass of three age
// subtract-compares and the fault word update runs from there into the result
// register, which also commits the state, so the next item sees it at once.
// Result backpressure stalls both registers together. The user must write
// timeouts through the cfg port only while no item is in flight (unenforced).
// ---------------------------------------------------------------------------
module heartbeat_watchdog_fault_register_core
	import hbwd_pkg::*;
#(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,  // [31:0] now_tick, [63:32] fault_mask
	input  logic [KIND_W-1:0]    s_tuser,  // [2:0] kind
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] fault_word, [32] send_diag, [33] enter_dead_reckoning,
	// [34] disable_fusion, [35] bus_recover_and_log, [39:36] zero
	output logic [39:0]          m_tdata
);

	localparam int unsigned STAMP_W = (TICK_BITS < 32) ? TICK_BITS : 32;

	timeouts_t timeouts;

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [TICK_W-1:0]   tick_s1;
	logic [FAULT_W-1:0]  mask_s1;

	logic [FAULT_W-1:0]  fault_q;
	logic [STAMP_W-1:0]  pos_stamp_q;
	logic [STAMP_W-1:0]  inr_stamp_q;
	logic [STAMP_W-1:0]  bus_stamp_q;

	logic                out_valid_q;
	logic [FAULT_W-1:0]  out_word_q;
	logic                out_diag_q;
	logic                out_dr_q;
	logic                out_df_q;
	logic                out_br_q;

	logic                advance;
	logic [2:0]          chk_bit;
	logic [2:0]          chk_pulse;
	logic [FAULT_W-1:0]  fault_next;
	logic                diag_next;
	logic [2:0]          pulse_next;

	hbwd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.timeouts (timeouts)
	);

	hbwd_chan_check #(.TICK_BITS(TICK_BITS)) u_chk_pos (
		.now_tick(tick_s1),
		.stamp   (pos_stamp_q),
		.timeout (timeouts.pos),
		.bit_cur (fault_q[BIT_POS]),
		.bit_next(chk_bit[0]),
		.pulse   (chk_pulse[0])
	);

	hbwd_chan_check #(.TICK_BITS(TICK_BITS)) u_chk_inr (
		.now_tick(tick_s1),
		.stamp   (inr_stamp_q),
		.timeout (timeouts.inr),
		.bit_cur (fault_q[BIT_INR]),
		.bit_next(chk_bit[1]),
		.pulse   (chk_pulse[1])
	);

	hbwd_chan_check #(.TICK_BITS(TICK_BITS)) u_chk_bus (
		.now_tick(tick_s1),
		.stamp   (bus_stamp_q),
		.timeout (timeouts.bus),
		.bit_cur (fault_q[BIT_BUS]),
		.bit_next(chk_bit[2]),
		.pulse   (chk_pulse[2])
	);

	// both registers move together when the result slot is free or draining
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			tick_s1 <= s_tdata[31:0];
			mask_s1 <= s_tdata[63:32];
		end
	end

	always_comb begin
		fault_next = fault_q;
		diag_next  = 1'b0;
		pulse_next = 3'b000;
		case (kind_s1)
			KIND_MONITOR: begin
				fault_next[BIT_POS] = chk_bit[0];
				fault_next[BIT_INR] = chk_bit[1];
				fault_next[BIT_BUS] = chk_bit[2];
				pulse_next          = chk_pulse;
				diag_next           = |fault_next;
			end
			KIND_SET_MASK: fault_next = fault_q | mask_s1;
			KIND_CLR_MASK: fault_next = fault_q & ~mask_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= '0;
			pos_stamp_q <= '0;
			inr_stamp_q <= '0;
			bus_stamp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				fault_q     <= fault_next;
				out_valid_q <= 1'b1;
				case (kind_s1)
					KIND_BEAT_POS: pos_stamp_q <= STAMP_W'(tick_s1);
					KIND_BEAT_INR: inr_stamp_q <= STAMP_W'(tick_s1);
					KIND_BEAT_BUS: bus_stamp_q <= STAMP_W'(tick_s1);
					default: ;
				endcase
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= fault_next;
			out_diag_q <= diag_next;
			out_dr_q   <= pulse_next[0];
			out_df_q   <= pulse_next[1];
			out_br_q   <= pulse_next[2];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_br_q, out_df_q, out_dr_q, out_diag_q, out_word_q};

endmodule
